[rtl/quadtree_depth_lookup_macros.svh]
// Assertion helpers for the RTL that checks its own control logic (qdl_ctrl.sv).
`ifndef QUADTREE_DEPTH_LOOKUP_MACROS_SVH
`define QUADTREE_DEPTH_LOOKUP_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define QDL_ASSERT_SAME(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define QDL_ASSERT_NEXT(label, clk, rstn, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error(msg);

`endif

[rtl/qdl_pkg.sv]
package qdl_pkg;

    localparam logic [31:0] DEFAULT_DEPTH   = 32'h3F80_0000;
    localparam logic [10:0] TILE_EDGE_RESET = 11'd128;

    localparam int S_TDATA_W = 184;
    localparam int M_TDATA_W = 32;
    // Node memory word: {children[63:0], depth_valid, depth[31:0]}.
    localparam int NODE_WORD_W = 97;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } qdl_state_t;

    typedef struct packed {
        logic start;       // latch query fields and clear the accumulators
        logic node_write;  // write the incoming node entry
        logic walk;        // evaluate the node that the memory presents
        logic load_out;    // copy the accumulated result to the output register
    } qdl_cmd_t;

    typedef struct packed {
        logic root_ok;     // incoming query has a usable root inside its window
        logic walk_stop;   // current node ends the walk
    } qdl_sts_t;

endpackage

[rtl/qdl_ram.sv]
module qdl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/qdl_ctrl.sv]
`include "quadtree_depth_lookup_macros.svh"

module qdl_ctrl
    import qdl_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     s_opcode,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  qdl_sts_t sts,
    output qdl_cmd_t cmd
);

    qdl_state_t state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       accept;
    logic       out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd.start      = accept && (s_opcode == OP_QUERY);
        cmd.node_write = accept && (s_opcode == OP_WRITE);
        cmd.walk       = (state_reg == ST_WALK);
        cmd.load_out   = (state_reg == ST_DONE) && out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_opcode == OP_QUERY)) begin
                    state_next = sts.root_ok ? ST_WALK : ST_DONE;
                end
            end
            ST_WALK: begin
                if (sts.walk_stop) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `QDL_ASSERT_NEXT(a_root_ok_walks, aclk, aresetn, cmd.start && sts.root_ok, state_reg == ST_WALK, "query with a valid root did not start a walk")
    `QDL_ASSERT_NEXT(a_result_loaded, aclk, aresetn, cmd.load_out, m_tvalid_reg && (state_reg == ST_IDLE), "finished query did not present a result")
    `QDL_ASSERT_SAME(a_result_source, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg == ST_DONE), "result appeared without a finished query")

endmodule

[rtl/qdl_datapath.sv]
module qdl_datapath
    import qdl_pkg::*;
#(
    parameter int NODE_ENTRIES  = 32768,
    parameter int MAX_TILE_EDGE = 1024,
    parameter int MAX_STEPS     = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,
    input  qdl_cmd_t    cmd,
    output qdl_sts_t    sts,
    input  logic [14:0] node_addr,
    input  logic        node_depth_valid,
    input  logic [31:0] node_depth_bits,
    input  logic [63:0] node_child_slots,
    input  logic [15:0] tile_root,
    input  logic [14:0] tile_window_base,
    input  logic [15:0] tile_window_count,
    input  logic [9:0]  texel_x,
    input  logic [9:0]  texel_y,
    output logic        depth_found,
    output logic [31:0] depth_bits
);

    localparam int AW = $clog2(NODE_ENTRIES);
    localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    logic [10:0] tile_edge_reg;
    logic [14:0] base_reg;
    logic [16:0] limit_reg;
    logic [9:0]  x_reg, y_reg;
    logic [9:0]  min_x_reg, min_x_next;
    logic [9:0]  min_y_reg, min_y_next;
    logic [10:0] size_reg;
    logic [SW-1:0] step_reg;
    logic        found_reg;
    logic [31:0] depth_reg;
    logic        out_found_reg;
    logic [31:0] out_depth_reg;

    logic [16:0] in_limit;
    logic [14:0] root_n;
    logic        wr_in_range;
    logic [AW-1:0] rd_addr;
    logic [NODE_WORD_W-1:0] rd_word;
    logic [NODE_WORD_W-1:0] wr_word;

    logic        node_dv;
    logic [31:0] node_depth;
    logic [63:0] node_children;
    logic        has_child;
    logic [10:0] half;
    logic [9:0]  diff_x, diff_y;
    logic        cx, cy;
    logic [15:0] next_node;
    logic        next_ok;
    logic        step_last;

    // Configuration register, saturated to the largest supported tile.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_edge_reg <= TILE_EDGE_RESET;
        end else if (cfg_wr_en) begin
            if (32'(cfg_wr_data) > MAX_TILE_EDGE) begin
                tile_edge_reg <= 11'(MAX_TILE_EDGE);
            end else begin
                tile_edge_reg <= cfg_wr_data;
            end
        end
    end

    assign in_limit = {2'b00, tile_window_base} + {1'b0, tile_window_count};
    assign root_n   = tile_root[14:0];

    assign sts.root_ok = !tile_root[15] && (tile_window_count != 16'd0)
                         && (tile_edge_reg != 11'd0) && (32'(root_n) < NODE_ENTRIES)
                         && (root_n >= tile_window_base) && ({2'b00, root_n} < in_limit);

    assign wr_in_range = 32'(node_addr) < NODE_ENTRIES;
    assign wr_word     = {node_child_slots, node_depth_valid, node_depth_bits};

    // The memory reads every cycle: the root while idle, the chosen child while walking.
    assign rd_addr = cmd.walk ? next_node[AW-1:0] : root_n[AW-1:0];

    qdl_ram #(
        .WIDTH (NODE_WORD_W),
        .DEPTH (NODE_ENTRIES)
    ) u_node_ram (
        .clk     (aclk),
        .wr_en   (cmd.node_write && wr_in_range),
        .wr_addr (node_addr[AW-1:0]),
        .wr_data (wr_word),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign node_depth    = rd_word[31:0];
    assign node_dv       = rd_word[32];
    assign node_children = rd_word[96:33];

    assign has_child = !node_children[15] || !node_children[31]
                       || !node_children[47] || !node_children[63];

    assign half   = size_reg >> 1;
    assign diff_x = x_reg - min_x_reg;
    assign diff_y = y_reg - min_y_reg;
    assign cx     = {1'b0, diff_x} >= half;
    assign cy     = {1'b0, diff_y} >= half;

    always_comb begin
        case ({cy, cx})
            2'b00:   next_node = node_children[15:0];
            2'b01:   next_node = node_children[31:16];
            2'b10:   next_node = node_children[47:32];
            default: next_node = node_children[63:48];
        endcase
    end

    assign next_ok = !next_node[15] && (next_node[14:0] >= base_reg)
                     && ({2'b00, next_node[14:0]} < limit_reg)
                     && (32'(next_node[14:0]) < NODE_ENTRIES);

    assign step_last = (step_reg == SW'(MAX_STEPS - 1));

    assign sts.walk_stop = !has_child || (size_reg <= 11'd1) || !next_ok || step_last;

    assign min_x_next = min_x_reg + (cx ? half[9:0] : 10'd0);
    assign min_y_next = min_y_reg + (cy ? half[9:0] : 10'd0);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            base_reg  <= tile_window_base;
            limit_reg <= in_limit;
            x_reg     <= texel_x;
            y_reg     <= texel_y;
            min_x_reg <= 10'd0;
            min_y_reg <= 10'd0;
            size_reg  <= tile_edge_reg;
            step_reg  <= '0;
            found_reg <= 1'b0;
            depth_reg <= DEFAULT_DEPTH;
        end else if (cmd.walk) begin
            if (node_dv) begin
                found_reg <= 1'b1;
                depth_reg <= node_depth;
            end
            if (!sts.walk_stop) begin
                min_x_reg <= min_x_next;
                min_y_reg <= min_y_next;
                size_reg  <= half;
                step_reg  <= step_reg + SW'(1);
            end
        end
        if (cmd.load_out) begin
            out_found_reg <= found_reg;
            out_depth_reg <= depth_reg;
        end
    end

    assign depth_found = out_found_reg;
    assign depth_bits  = out_depth_reg;

endmodule

[rtl/quadtree_depth_lookup.sv]
// Node writes may follow one another in every cycle.
// A query visits one tree level per cycle, as each level costs one node memory read;
// its result is presented once the walk ends, and the request channel is ready again
// in the same cycle as the result appears.
// A result waiting on m_tready does not hold the request channel; the next query waits at its end.
// Reset clears the controller and the output valid and restores tile_edge to 128;
// the node memory is not cleared and must be written before it is queried.
module quadtree_depth_lookup
    import qdl_pkg::*;
#(
    parameter int NODE_ENTRIES  = 32768,
    parameter int MAX_TILE_EDGE = 1024,
    parameter int MAX_STEPS     = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: tile edge length in texels.
    input  logic                 cfg_wr_en,
    input  logic [10:0]          cfg_wr_data,
    // Request channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata from bit 0 up: node_addr[14:0], node_depth_valid[15],
    // node_depth_bits[47:16], node_child_slots[111:48], tile_root[127:112],
    // tile_window_base[142:128], tile_window_count[158:143], texel_x[168:159],
    // texel_y[178:169], zero padding[183:179].
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: opcode (0 writes a node, 1 runs a query).
    input  logic                 s_tuser,
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: depth_bits[31:0].
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: depth_found.
    output logic                 m_tuser
);

    // The controller sequences each request: a write goes straight into the node memory,
    // while a query checks its root, then, if the root is usable, walks one level per cycle
    // until the datapath signals a stop, and finally waits for the output register to be free.
    qdl_cmd_t cmd;
    qdl_sts_t sts;

    qdl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_opcode (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the node memory, the walk position and the depth accumulator.
    // The packed request fields are split out here at their documented positions.
    qdl_datapath #(
        .NODE_ENTRIES  (NODE_ENTRIES),
        .MAX_TILE_EDGE (MAX_TILE_EDGE),
        .MAX_STEPS     (MAX_STEPS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .cmd               (cmd),
        .sts               (sts),
        .node_addr         (s_tdata[14:0]),
        .node_depth_valid  (s_tdata[15]),
        .node_depth_bits   (s_tdata[47:16]),
        .node_child_slots  (s_tdata[111:48]),
        .tile_root         (s_tdata[127:112]),
        .tile_window_base  (s_tdata[142:128]),
        .tile_window_count (s_tdata[158:143]),
        .texel_x           (s_tdata[168:159]),
        .texel_y           (s_tdata[178:169]),
        .depth_found       (m_tuser),
        .depth_bits        (m_tdata)
    );

endmodule
